>>> sv/stereo_pair_radius_dedup_table_defines.svh
// assertion macros for the stereo pair dedup table top module
// no dependencies; taken in by `include where checks are written
`ifndef STEREO_PAIR_RADIUS_DEDUP_TABLE_DEFINES_SVH
`define STEREO_PAIR_RADIUS_DEDUP_TABLE_DEFINES_SVH

// same-cycle implication under synchronous reset
`define SRDT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication under synchronous reset
`define SRDT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/srdt_pkg.sv
// types and constants for the stereo pair dedup table
// no dependencies; used by every module of the block
package srdt_pkg;

   localparam int COORD_BITS     = 16;
   localparam int DELTA_BITS     = 12;
   localparam int FAR_DELTA      = 4096;
   localparam int SQ_BITS        = 2 * DELTA_BITS;
   localparam int DIST_BITS      = SQ_BITS + 1;
   localparam int RADIUS_BITS    = 24;
   localparam int COUNT_BITS     = 11;
   localparam int PAIR_BITS      = 4 * COORD_BITS;
   localparam int REQ_DATA_BITS  = PAIR_BITS;
   localparam int REQ_USER_BITS  = 2;
   localparam int RSP_DATA_BITS  = 24;
   localparam int RSP_USER_BITS  = 2;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CAPACITY_DEF   = 1024;

   localparam logic [RADIUS_BITS-1:0] MIN_DIST_RESET  = 24'd4096;
   localparam logic [COUNT_BITS-1:0]  MAX_PAIRS_RESET = 11'd320;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_MIN_DIST  = 1'b0,
      REG_MAX_PAIRS = 1'b1
   } csr_index_type;

   typedef enum logic [RSP_USER_BITS-1:0] {
      ST_INSERTED  = 2'd0,
      ST_DUPLICATE = 2'd1,
      ST_FULL      = 2'd2,
      ST_CLEARED   = 2'd3
   } status_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] ry;
      logic [COORD_BITS-1:0] rx;
      logic [COORD_BITS-1:0] ly;
      logic [COORD_BITS-1:0] lx;
   } pair_type;

   typedef struct packed {
      logic busy;
      logic hit_vld;
      logic hit;
   } unit_status_type;

endpackage

>>> sv/srdt_pair_mem.sv
// pair storage, one write port and one registered read port
// depends on srdt_pkg for the pair layout
module srdt_pair_mem #(
   parameter int DEPTH  = srdt_pkg::CAPACITY_DEF,
   parameter int ADDR_W = 10
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  srdt_pkg::pair_type    wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output srdt_pkg::pair_type    rd_data
);

   srdt_pkg::pair_type mem [0:DEPTH-1];
   srdt_pkg::pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/srdt_radius_unit.sv
// two-stage radius check of one stored pair against the offered pair
// depends on srdt_pkg for pair layout and widths
module srdt_radius_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_vld,
   input  srdt_pkg::pair_type                     stored,
   input  srdt_pkg::pair_type                     query,
   input  logic [srdt_pkg::RADIUS_BITS-1:0]       radius,
   output srdt_pkg::unit_status_type              status
);

   localparam int CB = srdt_pkg::COORD_BITS;
   localparam int DB = srdt_pkg::DELTA_BITS;
   localparam int SB = srdt_pkg::SQ_BITS;
   localparam int TB = srdt_pkg::DIST_BITS;

   function automatic logic [CB-1:0] abs_diff(input logic [CB-1:0] a, input logic [CB-1:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

   logic [CB-1:0] dlx, dly, drx, dry;
   logic          lfar_in, rfar_in;
   logic [SB-1:0] lsx_in, lsy_in, rsx_in, rsy_in;

   logic          s1_vld_ff, s2_vld_ff, hit_ff;
   logic          lfar_ff, rfar_ff;
   logic [SB-1:0] lsx_ff, lsy_ff, rsx_ff, rsy_ff;
   logic [TB-1:0] lsum, rsum;
   logic          hit_in;

   always_comb begin
      dlx = abs_diff(stored.lx, query.lx);
      dly = abs_diff(stored.ly, query.ly);
      drx = abs_diff(stored.rx, query.rx);
      dry = abs_diff(stored.ry, query.ry);
      // a component of FAR_DELTA or more is beyond any radius
      lfar_in = (dlx >= CB'(srdt_pkg::FAR_DELTA)) || (dly >= CB'(srdt_pkg::FAR_DELTA));
      rfar_in = (drx >= CB'(srdt_pkg::FAR_DELTA)) || (dry >= CB'(srdt_pkg::FAR_DELTA));
      lsx_in  = SB'(dlx[DB-1:0]) * SB'(dlx[DB-1:0]);
      lsy_in  = SB'(dly[DB-1:0]) * SB'(dly[DB-1:0]);
      rsx_in  = SB'(drx[DB-1:0]) * SB'(drx[DB-1:0]);
      rsy_in  = SB'(dry[DB-1:0]) * SB'(dry[DB-1:0]);
   end

   always_ff @(posedge clock) begin
      lsx_ff  <= lsx_in;
      lsy_ff  <= lsy_in;
      rsx_ff  <= rsx_in;
      rsy_ff  <= rsy_in;
      lfar_ff <= lfar_in;
      rfar_ff <= rfar_in;
   end

   always_comb begin
      lsum   = TB'(lsx_ff) + TB'(lsy_ff);
      rsum   = TB'(rsx_ff) + TB'(rsy_ff);
      hit_in = !lfar_ff && !rfar_ff && (lsum <= TB'(radius)) && (rsum <= TB'(radius));
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= in_vld;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   assign status.busy    = s1_vld_ff || s2_vld_ff;
   assign status.hit_vld = s2_vld_ff;
   assign status.hit     = hit_ff;

endmodule

>>> sv/stereo_pair_radius_dedup_table.sv
// offer: result is registered once the scan over every stored pair and the radius unit drain;
//   the scan reads one stored pair a cycle into the shared radius unit
// clear and table-full items: result registered in the cycle after accept
// throughput: one item at a time, next item taken once the result register is free or drained
// reset: synchronous, empties the table, zeroes the insert count, loads default radius
//   and limit; stored pairs are not cleared and are read only below the fill count
`include "stereo_pair_radius_dedup_table_defines.svh"

module stereo_pair_radius_dedup_table #(
   parameter int CAPACITY = srdt_pkg::CAPACITY_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // lx, ly, rx, ry from bit 0 up
   input  logic [srdt_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // command, count_insert from bit 0 up
   input  logic [srdt_pkg::REQ_USER_BITS-1:0]    req_tuser,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // stored_count, inserted_count, zero pad from bit 0 up
   output logic [srdt_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   // status
   output logic [srdt_pkg::RSP_USER_BITS-1:0]    rsp_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [srdt_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [srdt_pkg::RADIUS_BITS-1:0]      csr_data
);

   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int OB    = srdt_pkg::COUNT_BITS;
   localparam int CMP_W = (CW > OB) ? CW : OB;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic [srdt_pkg::RADIUS_BITS-1:0] min_dist_ff, min_dist_in;
   logic [OB-1:0]                    max_pairs_ff, max_pairs_in;
   logic [CW-1:0]                    entry_count_ff, entry_count_in;
   logic [CW-1:0]                    counted_ff, counted_in;
   logic [CW-1:0]                    issue_idx_ff, issue_idx_in;
   logic                             rd_vld_ff;
   logic                             hit_any_ff, hit_any_in;
   srdt_pkg::pair_type               query_ff, query_in;
   logic                             count_ins_ff, count_ins_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   srdt_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic [CW-1:0]                    rsp_stored_ff, rsp_stored_in;
   logic [CW-1:0]                    rsp_inserted_ff, rsp_inserted_in;

   srdt_pkg::pair_type               req_pair;
   srdt_pkg::pair_type               rd_data;
   srdt_pkg::unit_status_type        unit_st;
   logic                             req_accept, rsp_load;
   logic                             rd_en, wr_en, scan_done;
   logic [CMP_W-1:0]                 limit;
   logic                             table_full;

   assign req_pair   = srdt_pkg::pair_type'(req_tdata);
   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      limit = (CMP_W'(max_pairs_ff) > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY)
                                                        : CMP_W'(max_pairs_ff);
      table_full = CMP_W'(entry_count_ff) >= limit;
      rd_en      = (state_ff == S_SCAN) && (issue_idx_ff < entry_count_ff);
      scan_done  = (state_ff == S_SCAN) && (issue_idx_ff == entry_count_ff)
                   && !rd_vld_ff && !unit_st.busy;
   end

   always_comb begin
      min_dist_in     = min_dist_ff;
      max_pairs_in    = max_pairs_ff;
      state_in        = state_ff;
      entry_count_in  = entry_count_ff;
      counted_in      = counted_ff;
      issue_idx_in    = issue_idx_ff;
      hit_any_in      = hit_any_ff;
      query_in        = query_ff;
      count_ins_in    = count_ins_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_stored_in   = rsp_stored_ff;
      rsp_inserted_in = rsp_inserted_ff;
      rsp_load        = 1'b0;
      wr_en           = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            srdt_pkg::REG_MIN_DIST:  min_dist_in  = csr_data;
            srdt_pkg::REG_MAX_PAIRS: max_pairs_in = csr_data[OB-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_tuser[0]) begin
                  entry_count_in  = '0;
                  counted_in      = '0;
                  rsp_load        = 1'b1;
                  rsp_status_in   = srdt_pkg::ST_CLEARED;
                  rsp_stored_in   = '0;
                  rsp_inserted_in = '0;
               end else if (table_full) begin
                  rsp_load        = 1'b1;
                  rsp_status_in   = srdt_pkg::ST_FULL;
                  rsp_stored_in   = entry_count_ff;
                  rsp_inserted_in = counted_ff;
               end else begin
                  query_in     = req_pair;
                  count_ins_in = req_tuser[1];
                  issue_idx_in = '0;
                  hit_any_in   = 1'b0;
                  state_in     = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (rd_en) begin
               issue_idx_in = issue_idx_ff + CW'(1);
            end
            if (unit_st.hit_vld && unit_st.hit) begin
               hit_any_in = 1'b1;
            end
            if (scan_done) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
               if (hit_any_ff) begin
                  rsp_status_in   = srdt_pkg::ST_DUPLICATE;
                  rsp_stored_in   = entry_count_ff;
                  rsp_inserted_in = counted_ff;
               end else begin
                  wr_en          = 1'b1;
                  entry_count_in = entry_count_ff + CW'(1);
                  counted_in     = counted_ff + CW'(count_ins_ff);
                  rsp_status_in   = srdt_pkg::ST_INSERTED;
                  rsp_stored_in   = entry_count_in;
                  rsp_inserted_in = counted_in;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         min_dist_ff    <= srdt_pkg::MIN_DIST_RESET;
         max_pairs_ff   <= srdt_pkg::MAX_PAIRS_RESET;
         entry_count_ff <= '0;
         counted_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         rd_vld_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         min_dist_ff    <= min_dist_in;
         max_pairs_ff   <= max_pairs_in;
         entry_count_ff <= entry_count_in;
         counted_ff     <= counted_in;
         rsp_valid_ff   <= rsp_valid_in;
         rd_vld_ff      <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      issue_idx_ff    <= issue_idx_in;
      hit_any_ff      <= hit_any_in;
      query_ff        <= query_in;
      count_ins_ff    <= count_ins_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_stored_ff   <= rsp_stored_in;
      rsp_inserted_ff <= rsp_inserted_in;
   end

   srdt_pair_mem #(
      .DEPTH  (CAPACITY),
      .ADDR_W (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (entry_count_ff[AW-1:0]),
      .wr_data (query_ff),
      .rd_en   (rd_en),
      .rd_addr (issue_idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   srdt_radius_unit u_radius (
      .clock  (clock),
      .reset  (reset),
      .in_vld (rd_vld_ff),
      .stored (rd_data),
      .query  (query_ff),
      .radius (min_dist_ff),
      .status (unit_st)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {(srdt_pkg::RSP_DATA_BITS - 2 * OB)'(0),
                        OB'(rsp_inserted_ff), OB'(rsp_stored_ff)};

   `SRDT_ASSERT_NOW(a_fill_in_range, clock, reset, 1'b1,
      entry_count_ff <= CW'(CAPACITY), "fill count above capacity")
   `SRDT_ASSERT_NOW(a_counted_le_fill, clock, reset, 1'b1,
      counted_ff <= entry_count_ff, "insert count above fill count")
   `SRDT_ASSERT_NOW(a_rsp_no_overwrite, clock, reset, rsp_load,
      !rsp_valid_ff || rsp_tready, "result beat overwritten before taken")
   `SRDT_ASSERT_NEXT(a_insert_grows, clock, reset, wr_en,
      entry_count_ff == $past(entry_count_ff) + CW'(1), "insert did not grow table")
   `SRDT_ASSERT_NOW(a_idle_quiet, clock, reset, state_ff == S_IDLE,
      !rd_vld_ff && !unit_st.busy, "scan pipeline active while idle")

endmodule
